/* hdl/nnu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor upscaler package
// Shared sizes, register indexes and payload widths.
// ----------------------------------------------------------------------------
package nnu_pkg;

   // Storage and limits
   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_SCALE    = 8;
   localparam int HEIGHT_LIMIT = 4096;

   // Field widths fixed by the register map and the pixel format
   localparam int CFG_W      = 13;
   localparam int SCALE_W    = 4;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int CSR_IDX_W  = 2;

   // Derived counter widths
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
   localparam int REP_W   = $clog2(MAX_SCALE);
   localparam int LEFT_W  = $clog2(MAX_SCALE);

   // Compare widths: wide enough for count + 1 and for the raw register
   localparam int WCMP_W = ((COL_W + 1) > CFG_W) ? (COL_W + 1) : CFG_W;
   localparam int HCMP_W = ((ROW_W + 1) > CFG_W) ? (ROW_W + 1) : CFG_W;
   localparam int SCMP_W = ((REP_W + 1) > SCALE_W) ? (REP_W + 1) : SCALE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_SCALE        = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL  = 1'b0,
      CMD_REPLAY = 1'b1
   } command_type;

   localparam logic [CFG_W-1:0]   LINE_WIDTH_RST   = CFG_W'(640);
   localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = CFG_W'(480);
   localparam logic [SCALE_W-1:0] SCALE_RST        = SCALE_W'(2);

endpackage

/* hdl/nnu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor upscaler channels
// Valid/ready interfaces for the source pixel and output pixel streams.
// ----------------------------------------------------------------------------
interface nnu_req_if import nnu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;

   modport source (output valid, command, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

interface nnu_rsp_if import nnu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic              last_of_run;
   logic              end_of_row;
   logic              end_of_frame;

   modport source (output valid, out_red, out_green, out_blue, last_of_run, end_of_row,
                   end_of_frame, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, last_of_run, end_of_row,
                   end_of_frame, output ready);
endinterface

/* hdl/nearest_neighbor_upscaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor upscaler
// Enlarges an RGB raster by an integer factor, row-major output.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per source item. Command 0 delivers a
//   source pixel: it is stored in the line buffer and sent out scale times
//   (first output row of a group). Command 1 replays the next buffered
//   column scale times for each of the remaining scale-1 rows. A command
//   that does not fit the current mode is accepted and dropped silently.
//   rsp_chan carries one output pixel per transaction, with last_of_run,
//   end_of_row and end_of_frame marking run, row and frame ends.
//   csr_* writes line_width, frame_height and scale; write only while idle.
// Timing:
//   The accepting edge loads the read stage; the item moves on into the copy
//   register once that register is free, and the copy register drives rsp_chan.
//   The copy register sends one pixel per cycle while rsp_chan is ready, so an
//   item yields scale copies (2 at reset); a dropped command never enters the
//   read stage. The copy counter sets the rate.
// Reset:
//   Synchronous reset restores the register defaults (640 x 480, scale 2)
//   and clears counters and mode. Line buffer contents are not cleared.
// Backpressure:
//   When rsp_chan stalls the copy register holds, one more item waits in
//   the read stage, and req_chan.ready drops until that stage can advance.
// ----------------------------------------------------------------------------
module nearest_neighbor_upscaler import nnu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   nnu_req_if.sink              req_chan,
   nnu_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   // Configuration registers
   logic [CFG_W-1:0]   line_width_ff;
   logic [CFG_W-1:0]   frame_height_ff;
   logic [SCALE_W-1:0] scale_ff;

   // Frame position state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [REP_W-1:0] rep_ff, rep_in;
   logic             replaying_ff, replaying_in;

   // Read stage
   logic              s1_valid_ff;
   logic              s1_replay_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              s1_row_end_ff;
   logic              s1_frame_end_ff;
   logic [LEFT_W-1:0] s1_left_ff;

   // Copy register (drives rsp_chan)
   logic              em_valid_ff;
   logic [PIX_W-1:0]  em_pix_ff;
   logic              em_row_end_ff;
   logic              em_frame_end_ff;
   logic [LEFT_W-1:0] em_left_ff;

   // Effective (clamped) limits
   logic [WCMP_W-1:0] w_eff, w_raw;
   logic [HCMP_W-1:0] h_eff, h_raw;
   logic [SCMP_W-1:0] s_eff, s_raw;

   logic             accept;
   logic             is_replay;
   logic             cmd_ok;
   logic             row_end, group_end, frame_end;
   logic [PIX_W-1:0] req_pix;
   logic [PIX_W-1:0] ram_rd_data;
   logic             em_free;
   logic             s1_move;
   logic             rsp_fire;

   // -------------------------------------------------------------------------
   // Configuration port
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         scale_ff        <= SCALE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            CSR_SCALE:        scale_ff        <= csr_wr_data[SCALE_W-1:0];
            default: ;        // unmapped index: drop the write
         endcase
      end
   end

   // Clamp registers to their legal ranges; zero counts as one
   always_comb begin
      w_raw = WCMP_W'(line_width_ff);
      h_raw = HCMP_W'(frame_height_ff);
      s_raw = SCMP_W'(scale_ff);

      priority if (w_raw == '0)                 w_eff = WCMP_W'(1);
      else if (w_raw > WCMP_W'(MAX_WIDTH))      w_eff = WCMP_W'(MAX_WIDTH);
      else                                      w_eff = w_raw;

      priority if (h_raw == '0)                 h_eff = HCMP_W'(1);
      else if (h_raw > HCMP_W'(HEIGHT_LIMIT))   h_eff = HCMP_W'(HEIGHT_LIMIT);
      else                                      h_eff = h_raw;

      priority if (s_raw == '0)                 s_eff = SCMP_W'(1);
      else if (s_raw > SCMP_W'(MAX_SCALE))      s_eff = SCMP_W'(MAX_SCALE);
      else                                      s_eff = s_raw;
   end

   // -------------------------------------------------------------------------
   // Handshake and flow control
   // -------------------------------------------------------------------------
   assign rsp_fire = em_valid_ff && rsp_chan.ready;
   // Copy register frees up after the last copy of its run leaves
   assign em_free  = !em_valid_ff || (rsp_fire && (em_left_ff == '0));
   assign s1_move  = s1_valid_ff && em_free;

   assign req_chan.ready = !s1_valid_ff || em_free;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_replay = (command_type'(req_chan.command) == CMD_REPLAY);
   assign cmd_ok    = accept && (is_replay == replaying_ff);
   assign req_pix   = {req_chan.in_red, req_chan.in_green, req_chan.in_blue};

   // -------------------------------------------------------------------------
   // Frame position: flags and next counters for the accepted item
   // -------------------------------------------------------------------------
   always_comb begin
      row_end   = (WCMP_W'(col_ff) + WCMP_W'(1)) >= w_eff;
      group_end = is_replay ? ((SCMP_W'(rep_ff) + SCMP_W'(1)) >= s_eff)
                            : (s_eff <= SCMP_W'(1));
      frame_end = row_end && group_end && ((HCMP_W'(row_ff) + HCMP_W'(1)) >= h_eff);

      col_in       = col_ff;
      row_in       = row_ff;
      rep_in       = rep_ff;
      replaying_in = replaying_ff;

      if (cmd_ok) begin
         if (!row_end) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            priority if (group_end) begin
               replaying_in = 1'b0;
               rep_in       = '0;
               row_in       = ((HCMP_W'(row_ff) + HCMP_W'(1)) >= h_eff) ? '0
                                                                        : row_ff + ROW_W'(1);
            end else if (!replaying_ff) begin
               replaying_in = 1'b1;
               rep_in       = REP_W'(1);
            end else begin
               rep_in = rep_ff + REP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rep_ff       <= '0;
         replaying_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rep_ff       <= rep_in;
         replaying_ff <= replaying_in;
      end
   end

   // -------------------------------------------------------------------------
   // Line buffer: write on a source pixel, read on a replay. Each access
   // happens at its own acceptance, so a replay always sees earlier writes.
   // Read data holds until the next replay read, which needs s1 to advance.
   // -------------------------------------------------------------------------
   nnu_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd_ok && !is_replay),
      .wr_addr (col_ff),
      .wr_data (req_pix),
      .rd_en   (cmd_ok && is_replay),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // -------------------------------------------------------------------------
   // Read stage and copy register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         em_valid_ff <= 1'b0;
      end else begin
         // Read stage: load a kept item, drop it once it moves on
         if (cmd_ok) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         // Copy register: count down copies, then reload or go empty
         if (s1_move) begin
            em_valid_ff <= 1'b1;
         end else if (em_free) begin
            em_valid_ff <= 1'b0;
         end
      end

      if (cmd_ok) begin
         s1_replay_ff    <= is_replay;
         s1_pix_ff       <= req_pix;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
         s1_left_ff      <= LEFT_W'(s_eff - SCMP_W'(1));
      end

      if (s1_move) begin
         em_pix_ff       <= s1_replay_ff ? ram_rd_data : s1_pix_ff;
         em_row_end_ff   <= s1_row_end_ff;
         em_frame_end_ff <= s1_frame_end_ff;
         em_left_ff      <= s1_left_ff;
      end else if (rsp_fire && (em_left_ff != '0)) begin
         em_left_ff <= em_left_ff - LEFT_W'(1);
      end
   end

   assign rsp_chan.valid        = em_valid_ff;
   assign rsp_chan.out_red      = em_pix_ff[PIX_W-1 -: CHAN_W];
   assign rsp_chan.out_green    = em_pix_ff[2*CHAN_W-1 -: CHAN_W];
   assign rsp_chan.out_blue     = em_pix_ff[CHAN_W-1:0];
   assign rsp_chan.last_of_run  = (em_left_ff == '0);
   assign rsp_chan.end_of_row   = (em_left_ff == '0) && em_row_end_ff;
   assign rsp_chan.end_of_frame = (em_left_ff == '0) && em_frame_end_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   // Replay mode and a nonzero replay row index go together
   assert property (@(posedge clock) disable iff (reset)
      replaying_ff == (rep_ff != '0))
      else $error("replay mode and replay row index disagree");

   // A stalled copy register keeps its item and its copy count
   assert property (@(posedge clock) disable iff (reset)
      em_valid_ff && !rsp_chan.ready |=> em_valid_ff && $stable(em_left_ff)
                                         && $stable(em_pix_ff))
      else $error("copy register changed while stalled");

   // Frame end comes only on the last copy of a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_frame |-> rsp_chan.end_of_row
                                                  && rsp_chan.last_of_run)
      else $error("end of frame without end of row");

   // The read stage never takes a new item while a held one cannot leave
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !em_free |-> !req_chan.ready)
      else $error("read stage overrun");

endmodule

/* hdl/nnu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nnu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/nearest_neighbor_upscaler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor upscaler testbench
// Drives source pixels and replay commands into the upscaler, predicts the output
// with a local copy of the scaling counters and line buffer (or takes a run typed
// into the table), and checks the output in order under random idling and stalls.
// ----------------------------------------------------------------------------
module nearest_neighbor_upscaler_test;
   import nnu_pkg::*;

   localparam int          IDLE_PCT      = 7;       // idle cycles per hundred, each side
   localparam int          SETTLE_CYCLES = 8;       // covers the two-stage latency and drops
   localparam int          HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int          RANDOM_ITEMS  = 80;      // scaled source items in the random part
   localparam int unsigned CYCLE_LIMIT   = 400000;

   // One output pixel as the block presents it
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_of_run;
      logic              end_of_row;
      logic              end_of_frame;
   } out_pixel_type;

   // One row of the directed table: a register write or a request transaction
   typedef struct {
      bit                is_cfg;
      csr_index_type     idx;
      logic [CFG_W-1:0]  data;
      command_type       cmd;
      logic [PIX_W-1:0]  pix;
      bit                typed;      // expected run typed in below instead of predicted
      int unsigned       copies;
      bit                row_end;
      bit                frame_end;
   } step_row_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wr_data;

   nnu_req_if req_bus ();
   nnu_rsp_if rsp_bus ();

   nearest_neighbor_upscaler uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow registers and scaler state
   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   logic [SCALE_W-1:0] scale_reg;
   logic [PIX_W-1:0]   line_store [MAX_WIDTH];
   int unsigned        col_cnt;
   int unsigned        row_cnt;
   int unsigned        rep_cnt;
   bit                 replay_mode;

   out_pixel_type expected_pixels [$];
   step_row_type  plan [$];
   int unsigned   mismatches;
   bit            no_gaps;
   bit            hold_request;

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // End the run if it hangs
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("nearest_neighbor_upscaler_test: FAIL");
      $finish;
   end

   function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Queue n copies of a pixel; flags go on the last copy only
   function automatic void push_run(input logic [PIX_W-1:0] pix, input int unsigned n,
                                    input bit row_end, input bit frame_end);
      out_pixel_type copy;
      for (int unsigned k = 0; k < n; k++) begin
         copy.red          = pix[3*CHAN_W-1:2*CHAN_W];
         copy.green        = pix[2*CHAN_W-1:CHAN_W];
         copy.blue         = pix[CHAN_W-1:0];
         copy.last_of_run  = (k + 1 == n);
         copy.end_of_row   = (k + 1 == n) && row_end;
         copy.end_of_frame = (k + 1 == n) && frame_end;
         expected_pixels.push_back(copy);
      end
   endfunction

   // Advance the scaler by one accepted transaction; return the copy count
   function automatic int unsigned upscale_step(input command_type cmd,
                                                input logic [PIX_W-1:0] src, input bit record);
      int unsigned      w, h, s;
      logic [PIX_W-1:0] pix;
      bit               row_end, group_end, frame_end;
      w = clamp_to(width_reg, MAX_WIDTH);
      h = clamp_to(height_reg, HEIGHT_LIMIT);
      s = clamp_to(scale_reg, MAX_SCALE);
      if (cmd == CMD_PIXEL) begin
         if (replay_mode) return 0;     // pixel during replay: drop
         pix = src;
         line_store[col_cnt] = src;
         group_end = (s <= 1);
      end else begin
         if (!replay_mode) return 0;    // replay during loading: drop
         pix = line_store[col_cnt];
         group_end = (rep_cnt + 1 >= s);
      end
      row_end   = (col_cnt + 1 >= w);
      frame_end = row_end && group_end && (row_cnt + 1 >= h);
      if (record) push_run(pix, s, row_end, frame_end);
      if (!row_end) begin
         col_cnt++;
      end else begin
         col_cnt = 0;
         if (group_end) begin
            replay_mode = 1'b0;
            rep_cnt     = 0;
            row_cnt     = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
         end else if (!replay_mode) begin
            replay_mode = 1'b1;
            rep_cnt     = 1;
         end else begin
            rep_cnt++;
         end
      end
      return s;
   endfunction

   function automatic step_row_type cfg_row(input csr_index_type idx, input int unsigned data);
      return '{is_cfg: 1'b1, idx: idx, data: CFG_W'(data), cmd: CMD_PIXEL, pix: '0,
               typed: 1'b0, copies: 0, row_end: 1'b0, frame_end: 1'b0};
   endfunction

   function automatic step_row_type px_row(input command_type cmd,
                                           input logic [PIX_W-1:0] pix,
                                           input bit typed, input int unsigned copies,
                                           input bit row_end, input bit frame_end);
      return '{is_cfg: 1'b0, idx: CSR_LINE_WIDTH, data: '0, cmd: cmd, pix: pix,
               typed: typed, copies: copies, row_end: row_end, frame_end: frame_end};
   endfunction

   // Write one register at the next edge; the caller drops the enable afterwards
   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_LINE_WIDTH:   width_reg  = data;
         CSR_FRAME_HEIGHT: height_reg = data;
         CSR_SCALE:        scale_reg  = data[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one request transaction and return at the edge that accepts it
   task automatic offer(input command_type cmd, input logic [PIX_W-1:0] pix);
      while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.in_red   <= pix[3*CHAN_W-1:2*CHAN_W];
      req_bus.in_green <= pix[2*CHAN_W-1:CHAN_W];
      req_bus.in_blue  <= pix[CHAN_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop offering, wait out every expected pixel, then let dropped commands drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Output side: check each accepted transaction, then pick the next ready
   initial begin : pixel_sink
      int unsigned   hold_left;
      out_pixel_type got, want;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_red, rsp_bus.out_green, rsp_bus.out_blue,
                    rsp_bus.last_of_run, rsp_bus.end_of_row, rsp_bus.end_of_frame};
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel r=%02h g=%02h b=%02h last=%0b eor=%0b eof=%0b",
                           got.red, got.green, got.blue, got.last_of_run,
                           got.end_of_row, got.end_of_frame);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.last_of_run !== want.last_of_run ||
                   got.end_of_row !== want.end_of_row ||
                   got.end_of_frame !== want.end_of_frame) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %02h %02h %02h %0b%0b%0b got %02h %02h %02h %0b%0b%0b",
                              want.red, want.green, want.blue, want.last_of_run,
                              want.end_of_row, want.end_of_frame, got.red, got.green,
                              got.blue, got.last_of_run, got.end_of_row, got.end_of_frame);
               end
            end
         end
         // Hold ready low for a long stretch once, so the block backs up into req_bus
         if (hold_left == 0 && hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Stimulus: directed table, then random phases
   initial begin : stimulus
      bit               cfg_open;
      int unsigned      phase, useful, budget, w_cur;
      command_type      cmd;
      logic [PIX_W-1:0] pix;
      logic [CFG_W-1:0] w_raw, h_raw, s_raw;

      // Drive every input from time zero and hold reset
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_LINE_WIDTH;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= CMD_PIXEL;
      req_bus.in_red   <= '0;
      req_bus.in_green <= '0;
      req_bus.in_blue  <= '0;
      mismatches   = 0;
      no_gaps      = 1'b0;
      hold_request = 1'b0;
      width_reg    = LINE_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      scale_reg    = SCALE_RST;
      col_cnt      = 0;
      row_cnt      = 0;
      rep_cnt      = 0;
      replay_mode  = 1'b0;

      // Reset defaults: 640 x 480, scale 2, loading mode
      plan.push_back(px_row(CMD_REPLAY, 24'h123456, 1, 0, 0, 0));  // replay while loading
      plan.push_back(px_row(CMD_PIXEL,  24'hff007f, 1, 2, 0, 0));
      // Shrink width to end at the running column; scale one ends the frame on the load row
      plan.push_back(cfg_row(CSR_LINE_WIDTH, 2));
      plan.push_back(cfg_row(CSR_FRAME_HEIGHT, 1));
      plan.push_back(cfg_row(CSR_SCALE, 1));
      plan.push_back(px_row(CMD_PIXEL,  24'h00ff00, 1, 1, 1, 1));
      // Zero in every register counts as one
      plan.push_back(cfg_row(CSR_LINE_WIDTH, 0));
      plan.push_back(cfg_row(CSR_FRAME_HEIGHT, 0));
      plan.push_back(cfg_row(CSR_SCALE, 0));
      plan.push_back(px_row(CMD_PIXEL,  24'hffffff, 1, 1, 1, 1));
      plan.push_back(px_row(CMD_PIXEL,  24'h000000, 1, 1, 1, 1));
      // Raw values above the limits clamp to the maximum
      plan.push_back(cfg_row(CSR_SCALE, 15));
      plan.push_back(cfg_row(CSR_LINE_WIDTH, 8191));
      plan.push_back(cfg_row(CSR_FRAME_HEIGHT, 8191));
      plan.push_back(px_row(CMD_PIXEL,  24'ha55ac3, 1, 8, 0, 0));
      plan.push_back(px_row(CMD_REPLAY, 24'h000000, 1, 0, 0, 0));
      // Width drops below the column: row ends now and replay starts
      plan.push_back(cfg_row(CSR_LINE_WIDTH, 1));
      plan.push_back(px_row(CMD_PIXEL,  24'h123456, 1, 8, 1, 0));
      plan.push_back(px_row(CMD_PIXEL,  24'hffffff, 1, 0, 0, 0));  // pixel while replaying
      plan.push_back(px_row(CMD_REPLAY, 24'h5a5a5a, 0, 0, 0, 0));
      plan.push_back(px_row(CMD_REPLAY, 24'ha5a5a5, 0, 0, 0, 0));
      // Scale drops below the replay count: the group ends at the next replay
      plan.push_back(cfg_row(CSR_SCALE, 3));
      plan.push_back(px_row(CMD_REPLAY, 24'h000000, 0, 0, 0, 0));
      // Small frame setting; its last row group ends on a replay row
      plan.push_back(cfg_row(CSR_LINE_WIDTH, 2));
      plan.push_back(cfg_row(CSR_FRAME_HEIGHT, 2));
      plan.push_back(cfg_row(CSR_SCALE, 2));
      plan.push_back(px_row(CMD_PIXEL,  24'h800100, 0, 0, 0, 0));
      plan.push_back(px_row(CMD_PIXEL,  24'h7ffe01, 0, 0, 0, 0));
      plan.push_back(px_row(CMD_REPLAY, 24'h000000, 0, 0, 0, 0));
      plan.push_back(px_row(CMD_REPLAY, 24'hffffff, 0, 0, 0, 0));
      // Exact maxima
      plan.push_back(cfg_row(CSR_LINE_WIDTH, MAX_WIDTH));
      plan.push_back(cfg_row(CSR_FRAME_HEIGHT, HEIGHT_LIMIT));
      plan.push_back(cfg_row(CSR_SCALE, MAX_SCALE));
      plan.push_back(px_row(CMD_PIXEL,  24'h0f0f0f, 1, 8, 0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; a run of register writes waits for the block to go idle
      cfg_open = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            if (!cfg_open) wait_idle();
            write_reg(plan[i].idx, plan[i].data);
            cfg_open = 1'b1;
         end else begin
            if (cfg_open) csr_wr_en <= 1'b0;
            cfg_open = 1'b0;
            offer(plan[i].cmd, plan[i].pix);
            void'(upscale_step(plan[i].cmd, plan[i].pix, !plan[i].typed));
            if (plan[i].typed) push_run(plan[i].pix, plan[i].copies, plan[i].row_end,
                                        plan[i].frame_end);
         end
      end

      // Random phases: new settings while idle, then mostly well-formed transactions
      phase  = 0;
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         wait_idle();
         no_gaps = (phase == 1);
         w_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 6));
         h_raw = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 4));
         s_raw = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 3));
         // Never widen the row during replay: columns past the loaded ones hold nothing
         w_cur = clamp_to(width_reg, MAX_WIDTH);
         if (replay_mode && clamp_to(w_raw, MAX_WIDTH) > w_cur)
            w_raw = CFG_W'($urandom_range(1, w_cur));
         write_reg(CSR_LINE_WIDTH, w_raw);
         write_reg(CSR_FRAME_HEIGHT, h_raw);
         write_reg(CSR_SCALE, s_raw);
         csr_wr_en <= 1'b0;
         if (phase == 3) hold_request = 1'b1;
         budget = (phase == 3) ? 24 : $urandom_range(6, 18);
         repeat (budget) begin
            pix = PIX_W'($urandom);
            // One in ten sends the wrong command for the mode
            if ($urandom_range(0, 9) == 0)
               cmd = replay_mode ? CMD_PIXEL : CMD_REPLAY;
            else
               cmd = replay_mode ? CMD_REPLAY : CMD_PIXEL;
            offer(cmd, pix);
            if (upscale_step(cmd, pix, 1'b1) != 0) useful++;
         end
         phase++;
      end

      wait_idle();
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("nearest_neighbor_upscaler_test: PASS");
      else
         $display("nearest_neighbor_upscaler_test: FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/nnu_pkg.sv
hdl/nnu_if.sv
hdl/nnu_ram.sv
hdl/nearest_neighbor_upscaler.sv
dv/nearest_neighbor_upscaler_test.sv
